/* hw/rtl/srfc_pkg.sv */
`timescale 1ns / 1ps

package srfc_pkg;

  localparam int unsigned MAX_REPLY_LEN = 128;
  localparam int unsigned CNT_W         = 8;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_EXPECT_FIRST   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXPECT_SECOND  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPLY_LENGTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VALUE_POSITION = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VALUE_SIZE     = 3'd4;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_SHORT      = 2'd1;
  localparam logic [1:0] ST_HEADER_BAD = 2'd2;
  localparam logic [1:0] ST_CRC_BAD    = 2'd3;

  localparam logic [CNT_W-1:0] LEN_MIN = 8'd2;
  localparam logic [CNT_W-1:0] LEN_MAX = CNT_W'(MAX_REPLY_LEN);

  typedef struct packed {
    logic [7:0] expect_first;
    logic [7:0] expect_second;
    logic [7:0] reply_length;
    logic [6:0] value_position;
    logic [2:0] value_size;
  } cfg_t;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  status;
  } result_t;

  // one byte through the reflected CRC-16, LSB first
  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else      c = c >> 1;
    end
    return c;
  endfunction

endpackage

/* hw/rtl/sensor_reply_frame_checker.sv */
`timescale 1ns / 1ps

// channel  | dir | tdata (low bit up)              | tuser | tlast
// in_      | in  | [7:0] rx_byte                   | -     | frame_end
// out_     | out | [1:0] status, [33:2] value, pad | -     | -
// cfg_     | in  | write only: cfg_we, cfg_index, cfg_wdata
//
// One byte per cycle sustained, except that a last byte waits while the result
// register is full. A byte is held in the input register, then CRC, header,
// length and value logic runs into the result register, which offers the result.
// Reset (rst_n low, synchronous) clears both stages, the frame state and
// the registers. A stalled result holds only bytes carrying tlast; other
// bytes keep flowing while the result waits.

module sensor_reply_frame_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] rx_byte
  input  logic                           in_tlast,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [39:0]                    out_tdata,  // [1:0] status, [33:2] value
  input  logic                           cfg_we,
  input  logic [srfc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_wdata
);

  srfc_pkg::cfg_t    cfg;
  srfc_pkg::result_t result;

  logic              in_valid_r, in_valid_nxt;
  logic [7:0]        in_byte_r;
  logic              in_last_r;
  logic              out_valid_r, out_valid_nxt;
  srfc_pkg::result_t out_result_r;
  logic              out_space;
  logic              advance;
  logic              in_xfer;

  srfc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  srfc_frame u_frame (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .step      (advance),
    .rx_byte   (in_byte_r),
    .frame_end (in_last_r),
    .result    (result)
  );

  assign out_space = !out_valid_r || out_tready;
  // only a last byte needs room in the result register
  assign advance   = in_valid_r && (!in_last_r || out_space);
  assign in_tready = !in_valid_r || advance;
  assign in_xfer   = in_tvalid && in_tready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_xfer)      in_valid_nxt = 1'b1;
    else if (advance) in_valid_nxt = 1'b0;

    out_valid_nxt = out_valid_r;
    if (advance && in_last_r) out_valid_nxt = 1'b1;
    else if (out_tready)      out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
    if (advance && in_last_r) out_result_r <= result;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_result_r.value, out_result_r.status};

  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(advance && in_last_r))
    else $error("result raised without a last byte");

  a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r && in_byte_r == $past(in_byte_r))
    else $error("input stage dropped a waiting byte");

endmodule

/* hw/rtl/srfc_cfg_regs.sv */
`timescale 1ns / 1ps

module srfc_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [srfc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_wdata,
  output srfc_pkg::cfg_t                 cfg
);

  srfc_pkg::cfg_t cfg_r;
  srfc_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        srfc_pkg::REG_EXPECT_FIRST:   cfg_nxt.expect_first   = cfg_wdata;
        srfc_pkg::REG_EXPECT_SECOND:  cfg_nxt.expect_second  = cfg_wdata;
        srfc_pkg::REG_REPLY_LENGTH:   cfg_nxt.reply_length   = cfg_wdata;
        srfc_pkg::REG_VALUE_POSITION: cfg_nxt.value_position = cfg_wdata[6:0];
        srfc_pkg::REG_VALUE_SIZE:     cfg_nxt.value_size     = cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.expect_first   <= 8'd0;
      cfg_r.expect_second  <= 8'd0;
      cfg_r.reply_length   <= srfc_pkg::LEN_MIN;
      cfg_r.value_position <= 7'd0;
      cfg_r.value_size     <= 3'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* hw/rtl/srfc_frame.sv */
`timescale 1ns / 1ps

module srfc_frame (
  input  logic                 clk,
  input  logic                 rst_n,
  input  srfc_pkg::cfg_t       cfg,
  input  logic                 step,
  input  logic [7:0]           rx_byte,
  input  logic                 frame_end,
  output srfc_pkg::result_t    result
);

  logic [srfc_pkg::CNT_W-1:0] byte_count_r, byte_count_nxt;
  logic [15:0]                crc_r, crc_nxt;
  logic [15:0]                window_r, window_nxt;
  logic                       header_ok_r, header_ok_nxt;
  logic [31:0]                value_r, value_nxt;

  logic [srfc_pkg::CNT_W-1:0] len_eff;
  logic                       take;
  logic [8:0]                 pos_end;
  logic [8:0]                 byte_dist;
  logic                       in_value;
  logic [15:0]                crc_got;

  always_comb begin
    if (cfg.reply_length < srfc_pkg::LEN_MIN)      len_eff = srfc_pkg::LEN_MIN;
    else if (cfg.reply_length > srfc_pkg::LEN_MAX) len_eff = srfc_pkg::LEN_MAX;
    else                                           len_eff = cfg.reply_length;
  end

  assign take      = byte_count_r < len_eff;
  assign pos_end   = {2'b00, cfg.value_position} + {6'd0, cfg.value_size};
  assign byte_dist = pos_end - 9'd1 - {1'b0, byte_count_r};
  assign in_value  = (cfg.value_size != 3'd0) &&
                     ({1'b0, byte_count_r} >= {2'b00, cfg.value_position}) &&
                     ({1'b0, byte_count_r} < pos_end);

  always_comb begin
    byte_count_nxt = byte_count_r;
    crc_nxt        = crc_r;
    window_nxt     = window_r;
    header_ok_nxt  = header_ok_r;
    value_nxt      = value_r;
    if (take) begin
      if (byte_count_r == 8'd0 && rx_byte != cfg.expect_first)  header_ok_nxt = 1'b0;
      if (byte_count_r == 8'd1 && rx_byte != cfg.expect_second) header_ok_nxt = 1'b0;
      // the byte two places back leaves the window and goes into the CRC
      if (byte_count_r >= 8'd2) crc_nxt = srfc_pkg::crc_update(crc_r, window_r[15:8]);
      window_nxt = {window_r[7:0], rx_byte};
      // only the last four value bytes land in the low 32 bits
      if (in_value && byte_dist < 9'd4)
        value_nxt = value_r | ({24'd0, rx_byte} << {byte_dist[1:0], 3'b000});
      byte_count_nxt = byte_count_r + 8'd1;
    end
  end

  // trailing CRC arrives low byte first
  assign crc_got = {window_nxt[7:0], window_nxt[15:8]};

  always_comb begin
    result.value = 32'd0;
    if (byte_count_nxt < len_eff) begin
      result.status = srfc_pkg::ST_SHORT;
    end else if (!header_ok_nxt) begin
      result.status = srfc_pkg::ST_HEADER_BAD;
    end else if (crc_got != crc_nxt) begin
      result.status = srfc_pkg::ST_CRC_BAD;
    end else begin
      result.status = srfc_pkg::ST_OK;
      result.value  = value_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      crc_r        <= srfc_pkg::CRC_INIT;
      window_r     <= 16'd0;
      header_ok_r  <= 1'b1;
      value_r      <= 32'd0;
    end else if (step) begin
      if (frame_end) begin
        byte_count_r <= '0;
        crc_r        <= srfc_pkg::CRC_INIT;
        window_r     <= 16'd0;
        header_ok_r  <= 1'b1;
        value_r      <= 32'd0;
      end else begin
        byte_count_r <= byte_count_nxt;
        crc_r        <= crc_nxt;
        window_r     <= window_nxt;
        header_ok_r  <= header_ok_nxt;
        value_r      <= value_nxt;
      end
    end
  end

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    byte_count_r <= srfc_pkg::LEN_MAX)
    else $error("byte count ran past the length limit");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step && frame_end |=> byte_count_r == '0 && crc_r == srfc_pkg::CRC_INIT && header_ok_r)
    else $error("frame state not cleared after last byte");

  a_value_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    result.status != srfc_pkg::ST_OK |-> result.value == 32'd0)
    else $error("value given on a failed reply");

  a_short_no_count: assert property (@(posedge clk) disable iff (!rst_n)
    step && !take |=> byte_count_r == $past(byte_count_r) || $past(frame_end))
    else $error("extra byte changed the count");

endmodule

/* bench/sensor_reply_frame_checker_test.sv */
`timescale 1ns / 1ps

module sensor_reply_frame_checker_test;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SET_ITEMS   = 55;

  typedef struct packed {
    logic [7:0] b;
    logic       fin;
  } rx_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] value;
  } reply_t;

  typedef enum {FR_GOOD, FR_BAD_HEADER, FR_BAD_CRC, FR_SHORT, FR_EXTRA, FR_NOISE} frame_kind_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [7:0]                     in_tdata = '0;    // [7:0] rx_byte
  logic                           in_tlast = 1'b0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [39:0]                    out_tdata;        // [1:0] status, [33:2] value
  logic                           cfg_we = 1'b0;
  logic [srfc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]                     cfg_wdata = '0;

  sensor_reply_frame_checker DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #1 clk = ~clk;

  // register mirror
  logic [7:0] exp_first = '0;
  logic [7:0] exp_second = '0;
  logic [7:0] reply_len = 8'd2;
  logic [6:0] val_pos = '0;
  logic [2:0] val_size = '0;

  // frame state of the checker
  int unsigned frm_cnt = 0;
  logic [15:0] frm_crc = srfc_pkg::CRC_INIT;
  logic [15:0] frm_win = '0;
  logic        frm_hdr_ok = 1'b1;
  logic [31:0] frm_val = '0;

  rx_item_t tx_bytes[$];
  reply_t   pending_replies[$];
  rx_item_t nxt;
  reply_t   want;
  int       send_idle = 0;
  int       recv_idle = 0;
  int       mismatches = 0;
  int       cycles = 0;
  int       set_items;
  logic     last_fin;

  // bitwise reflected CRC-16, one input bit per step
  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    logic fb;
    r = c;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ b[i];
      r = {1'b0, r[15:1]} ^ (fb ? srfc_pkg::CRC_POLY : 16'h0000);
    end
    return r;
  endfunction

  function automatic int unsigned eff_len();
    int unsigned l;
    l = reply_len;
    if (l < 2) l = 2;
    if (l > srfc_pkg::MAX_REPLY_LEN) l = srfc_pkg::MAX_REPLY_LEN;
    return l;
  endfunction

  task automatic take_byte(input logic [7:0] b, input logic fin);
    int unsigned lim, k, pos, size, sh;
    reply_t r;
    lim = eff_len();
    if (frm_cnt < lim) begin
      k = frm_cnt;
      pos = val_pos;
      size = val_size;
      if (k == 0 && b != exp_first) frm_hdr_ok = 1'b0;
      if (k == 1 && b != exp_second) frm_hdr_ok = 1'b0;
      // byte k-2 drops out of the window into the CRC
      if (k >= 2) frm_crc = crc_byte(frm_crc, frm_win[15:8]);
      frm_win = {frm_win[7:0], b};
      if (size != 0 && k >= pos && k < pos + size) begin
        sh = 8 * (pos + size - 1 - k);
        if (sh < 32) frm_val |= 32'(b) << sh;
      end
      frm_cnt = k + 1;
    end
    if (fin) begin
      r.value = '0;
      if (frm_cnt < lim) r.status = srfc_pkg::ST_SHORT;
      else if (!frm_hdr_ok) r.status = srfc_pkg::ST_HEADER_BAD;
      else if ({frm_win[7:0], frm_win[15:8]} != frm_crc) r.status = srfc_pkg::ST_CRC_BAD;
      else begin
        r.status = srfc_pkg::ST_OK;
        r.value = frm_val;
      end
      pending_replies.push_back(r);
      frm_cnt = 0;
      frm_crc = srfc_pkg::CRC_INIT;
      frm_win = '0;
      frm_hdr_ok = 1'b1;
      frm_val = '0;
    end
  endtask

  task automatic set_reg(input logic [srfc_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      srfc_pkg::REG_EXPECT_FIRST:   exp_first = val;
      srfc_pkg::REG_EXPECT_SECOND:  exp_second = val;
      srfc_pkg::REG_REPLY_LENGTH:   reply_len = val;
      srfc_pkg::REG_VALUE_POSITION: val_pos = val[6:0];
      srfc_pkg::REG_VALUE_SIZE:     val_size = val[2:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic pick_settings(input int sel);
    logic [7:0] f, s, l, p, z;
    f = 8'($urandom);
    s = 8'($urandom);
    l = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(12, 2));
    p = ($urandom_range(7) == 0) ? 8'($urandom_range(127)) : 8'($urandom_range(15));
    z = 8'($urandom_range(7));
    case (sel)
      0: begin
        f = 8'h00; s = 8'hFF; l = 8'd255; p = 8'd127; z = 8'd4;
      end
      1: begin
        f = 8'hFF; s = 8'h00; l = 8'd0; p = 8'd0; z = 8'd7;
      end
      2: begin
        l = 8'd128; p = 8'd124; z = 8'd4;
      end
      7: begin
        l = 8'd1; p = 8'd127; z = 8'd0;
      end
      13: begin
        l = 8'd128; p = 8'd0; z = 8'd5;
      end
      default: ;
    endcase
    set_reg(srfc_pkg::REG_EXPECT_FIRST, f);
    set_reg(srfc_pkg::REG_EXPECT_SECOND, s);
    set_reg(srfc_pkg::REG_REPLY_LENGTH, l);
    set_reg(srfc_pkg::REG_VALUE_POSITION, p);
    set_reg(srfc_pkg::REG_VALUE_SIZE, z);
  endtask

  task automatic queue_byte(input logic [7:0] b, input logic fin);
    tx_bytes.push_back('{b: b, fin: fin});
    set_items++;
    last_fin = fin;
  endtask

  task automatic queue_frame(input frame_kind_t kind);
    logic [7:0] fr[$];
    logic [15:0] c;
    int unsigned ln, n, idx, lo;
    ln = eff_len();
    if (kind == FR_NOISE) begin
      n = $urandom_range(5, 1);
      repeat (n) queue_byte(8'($urandom), $urandom_range(3) == 0);
      return;
    end
    for (int i = 0; i < ln; i++) fr.push_back(8'($urandom));
    fr[0] = exp_first;
    fr[1] = exp_second;
    if (kind == FR_BAD_HEADER) begin
      idx = $urandom_range(1);
      fr[idx][$urandom_range(7)] = ~fr[idx][$urandom_range(7)];
      fr[idx] = fr[idx] ^ 8'(1 << $urandom_range(7)) ^ 8'h01;
      if (fr[idx] == ((idx == 0) ? exp_first : exp_second)) fr[idx] = ~fr[idx];
    end
    c = srfc_pkg::CRC_INIT;
    for (int i = 0; i + 2 < ln; i++) c = crc_byte(c, fr[i]);
    fr[ln-2] = c[7:0];
    fr[ln-1] = c[15:8];
    if (kind == FR_BAD_CRC) begin
      lo = (ln > 2) ? 2 : 0;
      idx = $urandom_range(ln - 1, lo);
      fr[idx] = fr[idx] ^ 8'(1 << $urandom_range(7));
    end
    if (kind == FR_SHORT) begin
      n = $urandom_range(ln - 1, 1);
      while (fr.size() > n) void'(fr.pop_back());
    end
    if (kind == FR_EXTRA) repeat ($urandom_range(3, 1)) fr.push_back(8'($urandom));
    foreach (fr[i]) queue_byte(fr[i], i == fr.size() - 1);
  endtask

  task automatic fill_set(input int budget);
    int unsigned r;
    frame_kind_t kind;
    set_items = 0;
    while (set_items < budget) begin
      r = $urandom_range(99);
      kind = (r < 55) ? FR_GOOD : (r < 65) ? FR_BAD_HEADER : (r < 75) ? FR_BAD_CRC :
             (r < 83) ? FR_SHORT : (r < 91) ? FR_EXTRA : FR_NOISE;
      queue_frame(kind);
    end
    // close any open frame so the checker is idle for the next writes
    if (!last_fin) queue_byte(8'($urandom), 1'b1);
  endtask

  // sender holds off until every reply is back, then the pipeline settles
  task automatic drain();
    do @(posedge clk);
    while (tx_bytes.size() != 0 || in_tvalid || pending_replies.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // byte driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) take_byte(in_tdata, in_tlast);
      if (!in_tvalid || in_tready) begin
        if (tx_bytes.size() != 0 && $urandom_range(99) >= send_idle) begin
          nxt = tx_bytes.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= nxt.b;
          in_tlast <= nxt.fin;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // reply monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_replies.size() == 0) begin
          $display("%0t: unexpected reply, expected none, got status %0d value %h",
                   $time, out_tdata[1:0], out_tdata[33:2]);
          mismatches++;
        end else begin
          want = pending_replies.pop_front();
          if (out_tdata[1:0] !== want.status) begin
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, want.status, out_tdata[1:0]);
            mismatches++;
          end
          if (out_tdata[33:2] !== want.value) begin
            $display("%0t: value mismatch, expected %h, got %h",
                     $time, want.value, out_tdata[33:2]);
            mismatches++;
          end
        end
      end
      out_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL sensor_reply_frame_checker");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    send_idle = 21;
    recv_idle = 49;

    // reset settings: length two, zero header, no value
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b1);
    queue_byte(8'h5A, 1'b1);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b1);
    drain();
    set_reg(srfc_pkg::REG_EXPECT_FIRST, 8'h01);
    set_reg(srfc_pkg::REG_EXPECT_SECOND, 8'h03);
    set_reg(srfc_pkg::REG_REPLY_LENGTH, 8'd8);
    set_reg(srfc_pkg::REG_VALUE_POSITION, 8'd3);
    set_reg(srfc_pkg::REG_VALUE_SIZE, 8'd2);
    queue_frame(FR_GOOD);
    queue_frame(FR_EXTRA);
    drain();

    for (int m = 0; m < 3; m++) begin
      case (m)
        0: begin send_idle = 21; recv_idle = 49; end
        1: begin send_idle = 49; recv_idle = 21; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      for (int s = 0; s < 6; s++) begin
        pick_settings(m * 6 + s);
        fill_set(SET_ITEMS);
        drain();
      end
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_replies.size() == 0) begin
      $display("PASS sensor_reply_frame_checker");
    end else begin
      $display("FAIL sensor_reply_frame_checker");
    end
    $finish;
  end

endmodule
